// ----- design/mavg_pkg.sv -----
// shared constants and types for the moving average filter
package mavg_pkg;

  localparam int SAMPLE_BITS  = 16;
  localparam int MAX_WINDOW   = 64;
  localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
  localparam int CNT_BITS     = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS     = SAMPLE_BITS + SLOT_BITS;
  localparam int DIV_CNT_BITS = $clog2(SUM_BITS);
  localparam int WINDOW_RESET = 8;

  localparam int DATA_BITS = 32;
  localparam int ADDR_BITS = 3;
  localparam logic [ADDR_BITS-1:0] ADDR_WINDOW = '0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic [CNT_BITS-1:0]           count_t;
  typedef logic [SLOT_BITS-1:0]          slot_t;

  typedef struct packed {
    logic   clear;
    count_t window;
  } mavg_cfg_t;

  typedef struct packed {
    logic   vld;
    sum_t   sum;
    count_t fill;
  } mavg_acc_t;

  typedef struct packed {
    logic    vld;
    sample_t quot;
  } mavg_div_res_t;

endpackage

// ----- design/mavg_if.sv -----
// item channels of the moving average filter
interface mavg_in_if;
  import mavg_pkg::*;
  logic    valid;
  logic    ready;
  sample_t sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface mavg_out_if;
  import mavg_pkg::*;
  logic    valid;
  logic    ready;
  sample_t average;
  modport source (output valid, output average, input ready);
  modport sink (input valid, input average, output ready);
endinterface

// ----- design/mavg_cfg.sv -----
// apb register block holding the window length
module mavg_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mavg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mavg_pkg::DATA_BITS-1:0] pwdata,
  output logic [mavg_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready,
  output mavg_pkg::mavg_cfg_t            cfg
);
  import mavg_pkg::*;

  count_t window_r;
  count_t window_nxt;
  logic   wr_ok;

  assign wr_ok = psel && penable && pwrite && (paddr == ADDR_WINDOW) &&
                 (pwdata != '0) && (pwdata <= DATA_BITS'(MAX_WINDOW));

  always_comb begin
    window_nxt = window_r;
    if (wr_ok) begin
      window_nxt = pwdata[CNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= CNT_BITS'(WINDOW_RESET);
    end else begin
      window_r <= window_nxt;
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr == ADDR_WINDOW) ?
                      {{(DATA_BITS-CNT_BITS){1'b0}}, window_r} : '0;
  assign cfg.clear  = wr_ok;
  assign cfg.window = window_r;

endmodule

// ----- design/mavg_accum.sv -----
// history memory with read-modify-write of the running sum
module mavg_accum (
  input  logic                clk,
  input  logic                rst_n,
  input  mavg_pkg::mavg_cfg_t cfg,
  input  logic                start,
  input  mavg_pkg::sample_t   sample,
  output mavg_pkg::mavg_acc_t acc
);
  import mavg_pkg::*;

  sample_t mem [MAX_WINDOW];
  sample_t rd_data_r;
  sample_t smp_r;
  slot_t   slot_r;
  slot_t   slot_nxt;
  count_t  fill_r;
  count_t  fill_nxt;
  sum_t    sum_r;
  sum_t    sum_nxt;
  logic    rd_pend_r;
  logic    done_r;
  sample_t old_smp;
  count_t  slot_inc;

  always_ff @(posedge clk) begin
    if (start) begin
      rd_data_r <= mem[slot_r];
      smp_r     <= sample;
    end
    if (rd_pend_r) begin
      mem[slot_r] <= smp_r;
    end
  end

  // entries past the fill point were never written since the last clear
  assign old_smp  = (fill_r == cfg.window) ? rd_data_r : '0;
  assign slot_inc = {1'b0, slot_r} + CNT_BITS'(1);

  always_comb begin
    sum_nxt  = sum_r;
    slot_nxt = slot_r;
    fill_nxt = fill_r;
    if (cfg.clear) begin
      sum_nxt  = '0;
      slot_nxt = '0;
      fill_nxt = '0;
    end else if (rd_pend_r) begin
      sum_nxt  = sum_r
               - {{(SUM_BITS-SAMPLE_BITS){old_smp[SAMPLE_BITS-1]}}, old_smp}
               + {{(SUM_BITS-SAMPLE_BITS){smp_r[SAMPLE_BITS-1]}}, smp_r};
      slot_nxt = (slot_inc == cfg.window) ? '0 : slot_inc[SLOT_BITS-1:0];
      if (fill_r < cfg.window) begin
        fill_nxt = fill_r + CNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r     <= '0;
      slot_r    <= '0;
      fill_r    <= '0;
      rd_pend_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      sum_r     <= sum_nxt;
      slot_r    <= slot_nxt;
      fill_r    <= fill_nxt;
      rd_pend_r <= start;
      done_r    <= rd_pend_r;
    end
  end

  assign acc.vld  = done_r;
  assign acc.sum  = sum_r;
  assign acc.fill = fill_r;

`ifndef SYNTHESIS
  a_fill_le_window: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cfg.window) else $error("fill count exceeds window");
  a_slot_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, slot_r} < cfg.window) else $error("write slot outside window");
  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r < cfg.window |-> {1'b0, slot_r} == fill_r)
    else $error("write slot and fill count disagree before wrap");
`endif

endmodule

// ----- design/mavg_div.sv -----
// radix-2 restoring divider, signed sum by fill count, truncating
module mavg_div (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mavg_pkg::mavg_acc_t     acc,
  input  logic                    take,
  output mavg_pkg::mavg_div_res_t res
);
  import mavg_pkg::*;

  typedef enum logic [2:0] {
    DV_IDLE = 3'b001,
    DV_RUN  = 3'b010,
    DV_DONE = 3'b100
  } div_state_t;

  div_state_t              state_r;
  div_state_t              state_nxt;
  logic [SUM_BITS-1:0]     quo_r;
  logic [CNT_BITS-1:0]     rem_r;
  count_t                  div_r;
  logic                    neg_r;
  logic [DIV_CNT_BITS-1:0] cnt_r;
  logic [CNT_BITS:0]       rem_sh;
  logic [CNT_BITS+1:0]     diff;
  logic                    ge;
  logic [SUM_BITS-1:0]     quo_signed;

  assign rem_sh = {rem_r, quo_r[SUM_BITS-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, div_r};
  assign ge     = !diff[CNT_BITS+1];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE: begin
        if (acc.vld) begin
          state_nxt = DV_RUN;
        end
      end
      DV_RUN: begin
        if (cnt_r == DIV_CNT_BITS'(SUM_BITS - 1)) begin
          state_nxt = DV_DONE;
        end
      end
      DV_DONE: begin
        if (take) begin
          state_nxt = DV_IDLE;
        end
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == DV_IDLE && acc.vld) begin
      neg_r <= acc.sum[SUM_BITS-1];
      quo_r <= acc.sum[SUM_BITS-1] ? SUM_BITS'(-acc.sum) : SUM_BITS'(acc.sum);
      rem_r <= '0;
      div_r <= acc.fill;
      cnt_r <= '0;
    end else if (state_r == DV_RUN) begin
      quo_r <= {quo_r[SUM_BITS-2:0], ge};
      rem_r <= ge ? diff[CNT_BITS-1:0] : rem_sh[CNT_BITS-1:0];
      cnt_r <= cnt_r + DIV_CNT_BITS'(1);
    end
  end

  assign quo_signed = neg_r ? (~quo_r + SUM_BITS'(1)) : quo_r;
  assign res.vld    = (state_r == DV_DONE);
  assign res.quot   = quo_signed[SAMPLE_BITS-1:0];

endmodule

// ----- design/moving_average_filter_core.sv -----
// moving average filter top level: channels, apb port and output register
//
// Each input item is one signed sample; each produces one result item, the
// mean of the last window_length samples (fewer right after reset or a
// window write), truncated toward zero. From acceptance to result an item
// passes a read of the history memory, an update of it and of the running
// sum, a load of the divider, the bit-serial divider with one step per sum
// bit, and the move into the output register. One item is in work at a
// time; the next is accepted once the divider hands its result to the
// output register, even if that result still waits for the sink. Writing
// window_length (byte address 0, values 1 to 64, others ignored) restarts
// the average from empty; write it only while no item is in work.
module moving_average_filter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  mavg_in_if.sink                        in_ch,
  mavg_out_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [mavg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [mavg_pkg::DATA_BITS-1:0] pwdata,
  output logic [mavg_pkg::DATA_BITS-1:0] prdata,
  output logic                           pready
);
  import mavg_pkg::*;

  mavg_cfg_t     cfg;
  mavg_acc_t     acc;
  mavg_div_res_t div_res;
  logic          busy_r;
  logic          busy_nxt;
  logic          out_vld_r;
  logic          out_vld_nxt;
  sample_t       out_avg_r;
  logic          accept;
  logic          take;

  mavg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mavg_accum u_accum (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .start  (accept),
    .sample (in_ch.sample),
    .acc    (acc)
  );

  mavg_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .acc   (acc),
    .take  (take),
    .res   (div_res)
  );

  assign in_ch.ready = !busy_r;
  assign accept      = in_ch.valid && !busy_r;
  assign take        = div_res.vld && (!out_vld_r || out_ch.ready);

  always_comb begin
    busy_nxt = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end else if (take) begin
      busy_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (take) begin
      out_vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_avg_r <= div_res.quot;
    end
  end

  assign out_ch.valid   = out_vld_r;
  assign out_ch.average = out_avg_r;

endmodule

// ----- tb/sv/tb_moving_average_filter_core.sv -----
// testbench for the moving average filter: directed table, random windows and samples
module tb_moving_average_filter_core;
  import mavg_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int SETTLE_CYCLES   = 40;
  localparam int ITEMS_PER_PHASE = 450;
  localparam int N_DIRECTED      = 25;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WINDOW} row_kind_e;
  typedef enum logic [1:0] {MIX_ALL_MAX, MIX_ALL_MIN, MIX_ALTERNATE, MIX_RANDOM} sample_mix_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [31:0] value;
    logic        typed;
    sample_t     expected;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  mavg_in_if  in_ch ();
  mavg_out_if out_ch ();

  moving_average_filter_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  sample_t history_copy [MAX_WINDOW];
  longint  window_sum;
  int      window_len;
  int      next_slot;
  int      samples_held;

  sample_t expected_averages [$];
  sample_t head_average;
  int      mismatch_count;
  int      cycle_count;
  int      in_idle_pct;
  int      out_stall_pct;

  stim_row_t directed_rows [0:N_DIRECTED-1] = '{
    '{ROW_SAMPLE, 32'h7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, 32'h8000, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 32'h8000, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'h0000, 1'b0, 16'h0000},
    '{ROW_WINDOW, 32'd1,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'h8000, 1'b1, 16'h8000},
    '{ROW_SAMPLE, 32'h7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, 32'hffff, 1'b1, 16'hffff},
    '{ROW_SAMPLE, 32'h0001, 1'b1, 16'h0001},
    '{ROW_WINDOW, 32'd64,   1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'h7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, 32'h7fff, 1'b1, 16'h7fff},
    '{ROW_SAMPLE, 32'h8000, 1'b0, 16'h0000},
    '{ROW_WINDOW, 32'd0,    1'b0, 16'h0000},
    '{ROW_WINDOW, 32'd65,   1'b0, 16'h0000},
    '{ROW_WINDOW, 32'd127,  1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'h5555, 1'b0, 16'h0000},
    '{ROW_WINDOW, 32'd64,   1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'hfffb, 1'b1, 16'hfffb},
    '{ROW_SAMPLE, 32'hfff9, 1'b0, 16'h0000},
    '{ROW_WINDOW, 32'd2,    1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'h0003, 1'b1, 16'h0003},
    '{ROW_SAMPLE, 32'hfffc, 1'b1, 16'h0000},
    '{ROW_SAMPLE, 32'haaaa, 1'b0, 16'h0000},
    '{ROW_SAMPLE, 32'h7fff, 1'b0, 16'h0000}
  };

  function automatic void clear_window_state();
    for (int k = 0; k < MAX_WINDOW; k++) begin
      history_copy[k] = '0;
    end
    window_sum   = 0;
    next_slot    = 0;
    samples_held = 0;
  endfunction

  function automatic void apply_window(int unsigned value);
    if (value != 0 && value <= MAX_WINDOW) begin
      window_len = value;
      clear_window_state();
    end
  endfunction

  function automatic sample_t next_average(sample_t s);
    longint quotient;
    window_sum = window_sum - longint'(history_copy[next_slot]) + longint'(s);
    history_copy[next_slot] = s;
    next_slot = (next_slot + 1 >= window_len) ? 0 : next_slot + 1;
    if (samples_held < window_len) begin
      samples_held++;
    end
    quotient = window_sum / longint'(samples_held);
    return sample_t'(quotient);
  endfunction

  function automatic sample_t random_sample(sample_mix_e mix, int idx);
    sample_t s;
    case (mix)
      MIX_ALL_MAX: s = 16'h7fff;
      MIX_ALL_MIN: s = 16'h8000;
      MIX_ALTERNATE: s = idx[0] ? 16'h7fff : 16'h8000;
      default: begin
        case ($urandom_range(0, 7))
          0: s = 16'h7fff;
          1: s = 16'h8000;
          2: s = sample_t'($urandom_range(0, 15) - 8);
          default: s = sample_t'($urandom);
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic int unsigned pick_window();
    int unsigned w;
    case ($urandom_range(0, 9))
      0: w = 1;
      1, 2: w = MAX_WINDOW;
      3: w = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_WINDOW + 1, 127);
      default: w = $urandom_range(1, MAX_WINDOW);
    endcase
    return w;
  endfunction

  task automatic push_sample(input sample_t s, input logic typed, input sample_t typed_avg);
    sample_t predicted;
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) begin
      @(posedge clk);
    end
    predicted = next_average(s);
    expected_averages.push_back(typed ? typed_avg : predicted);
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_averages.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_cycle(input logic wr, input logic [DATA_BITS-1:0] wdata,
                           output logic [DATA_BITS-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_WINDOW;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) begin
      @(posedge clk);
    end
    rdata = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic program_window(input int unsigned value);
    logic [DATA_BITS-1:0] rdata;
    apb_cycle(1'b1, DATA_BITS'(value), rdata);
    apply_window(value);
    apb_cycle(1'b0, '0, rdata);
    if (rdata !== DATA_BITS'(window_len)) begin
      mismatch_count++;
      $display("%0t window readback mismatch: expected %0d actual %0d",
               $time, window_len, rdata);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_averages.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected average: expected none actual %0d", $time, out_ch.average);
      end else begin
        head_average = expected_averages.pop_front();
        if (out_ch.average !== head_average) begin
          mismatch_count++;
          $display("%0t average mismatch: expected %0d actual %0d",
                   $time, head_average, out_ch.average);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int          sent;
    int          seg_len;
    sample_mix_e mix;

    rst_n          = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_ch.valid    = 1'b0;
    in_ch.sample   = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    in_idle_pct    = 0;
    out_stall_pct  = 0;
    window_len     = WINDOW_RESET;
    clear_window_state();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < N_DIRECTED; r++) begin
      if (directed_rows[r].kind == ROW_WINDOW) begin
        settle();
        program_window(directed_rows[r].value);
      end else begin
        push_sample(sample_t'(directed_rows[r].value[15:0]), directed_rows[r].typed,
                    directed_rows[r].expected);
      end
    end
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 61;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 61;
        end
        default: begin
          in_idle_pct   = 28;
          out_stall_pct = 28;
        end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        seg_len = $urandom_range(20, 120);
        case ($urandom_range(0, 7))
          0: mix = MIX_ALL_MAX;
          1: mix = MIX_ALL_MIN;
          2: mix = MIX_ALTERNATE;
          default: mix = MIX_RANDOM;
        endcase
        program_window(pick_window());
        for (int i = 0; i < seg_len; i++) begin
          push_sample(random_sample(mix, i), 1'b0, '0);
        end
        sent += seg_len;
        settle();
      end
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- moving_average_filter_core.f -----
design/mavg_pkg.sv
design/mavg_if.sv
design/mavg_cfg.sv
design/mavg_accum.sv
design/mavg_div.sv
design/moving_average_filter_core.sv
tb/sv/tb_moving_average_filter_core.sv
